// ===== rtl/core/vmbr_pkg.sv =====
// vmbr_pkg: shared constants, payload structs and controller types for the
// variable-length message byte ring. No dependencies.
package vmbr_pkg;

   localparam int BUF_SIZE = 64;
   localparam int RPOS_W   = 6;
   localparam int WPOS_W   = 7;
   localparam int LEN_W    = 6;
   localparam int CNT_W    = 6;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 6'd16;

   localparam logic [WPOS_W-1:0] BUF_SIZE_W  = WPOS_W'(BUF_SIZE);
   localparam logic [RPOS_W-1:0] BUF_LAST_R  = RPOS_W'(BUF_SIZE - 1);
   localparam logic [LEN_W-1:0]  MAX_RUN     = LEN_W'(63);

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_DRAIN  = 1'b1;
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic       kind;
      logic       accepted;
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic accept_byte;
      logic accept_drain;
      logic issue_read;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pend;
      logic out_free;
      logic drain_empty;
      logic last_issue;
   } ctrl_status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

// ===== rtl/core/vmbr_ctrl.sv =====
// vmbr_ctrl: request acceptance and drain sequencing state machine.
// Depends on vmbr_pkg.
module vmbr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_mode,
   output logic                     req_stall,
   input  vmbr_pkg::ctrl_status_type status,
   output vmbr_pkg::ctrl_cmd_type    cmd
);
   import vmbr_pkg::*;

   state_type state_ff, state_in;
   logic      idle_ready;
   logic      accept;

   assign idle_ready = (state_ff == ST_IDLE) && !status.pend && status.out_free;
   assign req_stall  = !idle_ready;
   assign accept     = req_valid && idle_ready;

   always_comb begin
      cmd.accept_byte  = accept && (req_mode == MODE_WRITE);
      cmd.accept_drain = accept && (req_mode == MODE_DRAIN);
      cmd.issue_read   = (state_ff == ST_DRAIN) && (!status.pend || status.out_free);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept_drain && !status.drain_empty) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cmd.issue_read && status.last_issue) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/vmbr_datapath.sv =====
// vmbr_datapath: ring pointers, message tracking, byte store, drain read
// stage and result register. Depends on vmbr_pkg.
module vmbr_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  vmbr_pkg::req_payload_type    req_payload,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [vmbr_pkg::LEN_W-1:0]  csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output vmbr_pkg::rsp_payload_type    rsp_payload,
   input  vmbr_pkg::ctrl_cmd_type       cmd,
   output vmbr_pkg::ctrl_status_type    status
);
   import vmbr_pkg::*;

   logic [7:0]        mem [BUF_SIZE];

   logic [LEN_W-1:0]  max_len_ff;
   logic [RPOS_W-1:0] rpos_ff;
   logic [WPOS_W-1:0] wpos_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              in_msg_ff;
   logic              rej_ff;

   logic [RPOS_W-1:0] addr_ff;
   logic [LEN_W-1:0]  left_ff;
   logic [7:0]        rdata_ff;
   logic              dlast_ff;
   logic              pend_ff;

   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff;

   logic [WPOS_W-1:0] r_w;
   logic [WPOS_W-1:0] to_end;
   logic [WPOS_W:0]   seq_sum;
   logic [WPOS_W-1:0] wrap_diff;
   logic              refused;
   logic              start;
   logic              rej;
   logic [CNT_W-1:0]  cnt;
   logic              store;
   logic [CNT_W-1:0]  cnt_next;
   logic [WPOS_W-1:0] wr_sum;
   logic [RPOS_W-1:0] wr_addr;
   logic [WPOS_W-1:0] nw_sum;
   logic [WPOS_W-1:0] commit_pos;
   logic [WPOS_W:0]   len_raw;
   logic [LEN_W-1:0]  len;
   logic              load_out;
   logic [RPOS_W-1:0] first_addr;

   // room check
   assign r_w       = WPOS_W'(rpos_ff);
   assign to_end    = BUF_SIZE_W - wpos_ff;
   assign seq_sum   = {1'b0, wpos_ff} + (WPOS_W+1)'(max_len_ff);
   assign wrap_diff = WPOS_W'(max_len_ff) - to_end;
   assign refused   = ((wpos_ff < r_w) && (seq_sum >= (WPOS_W+1)'(r_w)))
                   || ((WPOS_W'(max_len_ff) > to_end) && (wrap_diff >= r_w));

   // message byte handling
   assign start    = !in_msg_ff;
   assign rej      = start ? refused : rej_ff;
   assign cnt      = start ? '0 : cnt_ff;
   assign store    = !rej && (cnt < max_len_ff);
   assign cnt_next = cnt + CNT_W'(store);
   assign wr_sum   = wpos_ff + WPOS_W'(cnt);
   assign wr_addr  = (wr_sum >= BUF_SIZE_W) ? RPOS_W'(wr_sum - BUF_SIZE_W)
                                            : RPOS_W'(wr_sum);
   assign nw_sum     = wpos_ff + WPOS_W'(cnt_next);
   assign commit_pos = (nw_sum > BUF_SIZE_W) ? (nw_sum - BUF_SIZE_W) : nw_sum;

   // drain length
   always_comb begin
      if (wpos_ff > r_w) begin
         len_raw = (WPOS_W+1)'(wpos_ff - r_w - WPOS_W'(1));
      end else begin
         len_raw = (WPOS_W+1)'(BUF_SIZE_W) - (WPOS_W+1)'(r_w) - (WPOS_W+1)'(1)
                 + (WPOS_W+1)'(wpos_ff);
      end
      len = (len_raw > (WPOS_W+1)'(MAX_RUN)) ? MAX_RUN : LEN_W'(len_raw);
   end

   assign first_addr = (rpos_ff == BUF_LAST_R) ? '0 : rpos_ff + RPOS_W'(1);
   assign load_out   = pend_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      status.pend        = pend_ff;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
      status.drain_empty = (len == '0);
      status.last_issue  = (left_ff == LEN_W'(1));
   end

   // byte store
   always_ff @(posedge clock) begin
      if (cmd.accept_byte && store) begin
         mem[wr_addr] <= req_payload.data_byte;
      end
      if (cmd.issue_read) begin
         rdata_ff <= mem[addr_ff];
         dlast_ff <= (left_ff == LEN_W'(1));
      end
   end

   // drain address and count
   always_ff @(posedge clock) begin
      if (cmd.accept_drain) begin
         addr_ff <= first_addr;
         left_ff <= len;
      end else if (cmd.issue_read) begin
         addr_ff <= (addr_ff == BUF_LAST_R) ? '0 : addr_ff + RPOS_W'(1);
         left_ff <= left_ff - LEN_W'(1);
      end
   end

   // pointers, message state, configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
         rpos_ff    <= '0;
         wpos_ff    <= WPOS_W'(1);
         cnt_ff     <= '0;
         in_msg_ff  <= 1'b0;
         rej_ff     <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_data;
         end
         if (cmd.accept_drain && (len != '0)) begin
            rpos_ff <= (wpos_ff == '0) ? BUF_LAST_R : RPOS_W'(wpos_ff - WPOS_W'(1));
         end
         if (cmd.accept_byte) begin
            if (req_payload.end_of_message) begin
               if (!rej) begin
                  wpos_ff <= commit_pos;
               end
               in_msg_ff <= 1'b0;
               rej_ff    <= 1'b0;
               cnt_ff    <= '0;
            end else begin
               in_msg_ff <= 1'b1;
               rej_ff    <= rej;
               cnt_ff    <= cnt_next;
            end
         end
         if (cmd.issue_read) begin
            pend_ff <= 1'b1;
         end else if (load_out) begin
            pend_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out || (cmd.accept_byte && req_payload.end_of_message)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff.kind        <= KIND_BYTE;
         rsp_ff.accepted    <= 1'b0;
         rsp_ff.out_byte    <= rdata_ff;
         rsp_ff.last_of_run <= dlast_ff;
      end else if (cmd.accept_byte && req_payload.end_of_message) begin
         rsp_ff.kind        <= KIND_STATUS;
         rsp_ff.accepted    <= !rej;
         rsp_ff.out_byte    <= 8'd0;
         rsp_ff.last_of_run <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/variable_message_byte_ring.sv =====
// variable_message_byte_ring_core: top level of the message byte ring.
// Depends on vmbr_pkg, vmbr_ctrl and vmbr_datapath.
//
//   channel   direction  handshake           payload
//   req_      in         valid / stall       req_payload_type
//   rsp_      out        valid / stall       rsp_payload_type
//   csr_      in         valid / ready       max_message_len, 6 bits
//
// the status result of a message leaves through the output register
// a drain of n bytes passes each byte through the store read register and the output register
// no request is taken during a drain or while a result is held under stall
// synchronous active-high reset; the byte store itself is not cleared
module variable_message_byte_ring_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  vmbr_pkg::req_payload_type   req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output vmbr_pkg::rsp_payload_type   rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [vmbr_pkg::LEN_W-1:0] csr_data
);
   import vmbr_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   vmbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_payload.mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vmbr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== tb/tb_variable_message_byte_ring_core.sv =====
// tb_variable_message_byte_ring_core: self-checking testbench for the message byte ring.
// Streams store and drain requests with random gaps and output stalls, predicts every
// result from its own ring model and compares in order. Depends on vmbr_pkg and the core.
module tb_variable_message_byte_ring_core;
   timeunit 1ns;
   timeprecision 1ps;
   import vmbr_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LEN_W-1:0] csr_data = '0;

   variable_message_byte_ring_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #2 clock = ~clock;

   // ring state as the block should hold it
   logic [7:0]        ring_bytes [BUF_SIZE];
   logic [RPOS_W-1:0] rd_ptr = '0;
   logic [WPOS_W-1:0] wr_ptr = WPOS_W'(1);
   int                msg_len = 0;
   bit                msg_open = 1'b0;
   bit                msg_dropped = 1'b0;
   logic [LEN_W-1:0]  max_len = MAX_LEN_RESET;

   req_payload_type request_queue [$];
   rsp_payload_type due_results [$];
   int pushed_count = 0;
   int taken_count = 0;
   int err_count = 0;
   int stored_msgs = 0;
   int refused_msgs = 0;
   int drained_bytes = 0;
   int csr_writes = 0;
   bit calm = 1'b0;
   int req_gap = 0;
   int stall_left = 0;

   function automatic int draw_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(25, 8);
   endfunction

   function automatic bit room_refused();
      int w, r, m, to_end;
      w = wr_ptr;
      r = rd_ptr;
      m = max_len;
      to_end = (w <= BUF_SIZE) ? BUF_SIZE - w : 0;
      return (w < r && w + m >= r) || (m > to_end && m - to_end >= r);
   endfunction

   task automatic ring_advance(input req_payload_type rq);
      int w, r, run, nw;
      rsp_payload_type res;
      w = wr_ptr;
      r = rd_ptr;
      if (rq.mode == MODE_DRAIN) begin
         run = (w > r) ? w - r - 1 : BUF_SIZE - r - 1 + w;
         if (run > MAX_RUN) run = MAX_RUN;
         for (int i = 0; i < run; i++) begin
            res.kind        = KIND_BYTE;
            res.accepted    = 1'b0;
            res.out_byte    = ring_bytes[(r + 1 + i) % BUF_SIZE];
            res.last_of_run = (i == run - 1);
            due_results.push_back(res);
         end
         if (run != 0) rd_ptr = RPOS_W'((w == 0) ? BUF_SIZE - 1 : w - 1);
      end else begin
         if (!msg_open) begin
            msg_open    = 1'b1;
            msg_len     = 0;
            msg_dropped = room_refused();
         end
         if (!msg_dropped && msg_len < max_len) begin
            ring_bytes[(w + msg_len) % BUF_SIZE] = rq.data_byte;
            msg_len++;
         end
         if (rq.end_of_message) begin
            if (msg_dropped) begin
               refused_msgs++;
            end else begin
               nw = w + msg_len;
               if (nw > BUF_SIZE) nw = ((nw - 1) % BUF_SIZE) + 1;
               wr_ptr = WPOS_W'(nw);
               stored_msgs++;
            end
            res.kind        = KIND_STATUS;
            res.accepted    = ~msg_dropped;
            res.out_byte    = 8'h00;
            res.last_of_run = 1'b1;
            due_results.push_back(res);
            msg_open    = 1'b0;
            msg_dropped = 1'b0;
            msg_len     = 0;
         end
      end
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (due_results.size() == 0) begin
         $error("result with nothing due: %h", got);
         err_count++;
      end else begin
         want = due_results.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            err_count++;
         end
         if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            err_count++;
         end
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            err_count++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
            err_count++;
         end
         if (want.kind == KIND_BYTE) drained_bytes++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_stall === 1'b0) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (request_queue.size() != 0) begin
            req_payload <= request_queue.pop_front();
            req_valid   <= 1'b1;
            req_gap = draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = draw_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) begin
            ring_advance(req_payload);
            taken_count++;
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result(rsp_payload);
      end
   end

   task automatic push_req(input logic mode, input logic [7:0] data, input logic eom);
      req_payload_type rq;
      rq.mode           = mode;
      rq.data_byte      = data;
      rq.end_of_message = eom;
      request_queue.push_back(rq);
      pushed_count++;
   endtask

   task automatic push_drain();
      push_req(MODE_DRAIN, 8'($urandom), 1'($urandom));
   endtask

   task automatic settle();
      while (taken_count != pushed_count || due_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [LEN_W-1:0] v);
      settle();
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      max_len = v;
      csr_writes++;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         if (i != 0 && $urandom_range(99) < 5) push_drain();
         push_req(MODE_WRITE, 8'($urandom), i == len - 1);
      end
   endtask

   initial begin
      int budget, roll, len, short_cap;
      int phase_len [5];
      phase_len = '{63, 1, 0, 40, 16};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty drain, one-byte message, extreme bytes
      push_drain();
      push_req(MODE_WRITE, 8'h00, 1'b1);
      push_req(MODE_WRITE, 8'hFF, 1'b0);
      push_req(MODE_WRITE, 8'h80, 1'b0);
      push_req(MODE_WRITE, 8'h7F, 1'b1);
      push_drain();
      // drain while a message is open
      push_req(MODE_WRITE, 8'h33, 1'b1);
      push_req(MODE_WRITE, 8'h44, 1'b0);
      push_req(MODE_WRITE, 8'h55, 1'b0);
      push_drain();
      push_req(MODE_WRITE, 8'h66, 1'b1);
      push_drain();
      // truncation
      write_max_len(LEN_W'(2));
      push_req(MODE_WRITE, 8'h01, 1'b0);
      push_req(MODE_WRITE, 8'h02, 1'b0);
      push_req(MODE_WRITE, 8'h03, 1'b0);
      push_req(MODE_WRITE, 8'h04, 1'b1);
      push_drain();
      // zero length limit
      write_max_len(LEN_W'(0));
      push_req(MODE_WRITE, 8'hAA, 1'b0);
      push_req(MODE_WRITE, 8'hBB, 1'b1);
      push_drain();
      // limit raised in the middle of a message
      write_max_len(LEN_W'(1));
      push_req(MODE_WRITE, 8'hC1, 1'b0);
      push_req(MODE_WRITE, 8'hC2, 1'b0);
      write_max_len(LEN_W'(3));
      push_req(MODE_WRITE, 8'hC3, 1'b0);
      push_req(MODE_WRITE, 8'hC4, 1'b1);
      push_drain();

      for (int p = 0; p < 5; p++) begin
         write_max_len(p == 2 ? LEN_W'($urandom_range(62, 2)) : LEN_W'(phase_len[p]));
         calm = (p == 3);
         budget = pushed_count + 6;
         while (pushed_count < budget) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
               push_drain();
            end else if (roll < 20) begin
               settle();
            end else if (roll < 24) begin
               push_req(MODE_WRITE, 8'($urandom), 1'($urandom));
            end else begin
               short_cap = (max_len > 10) ? 12 : int'(max_len) + 2;
               len = ($urandom_range(9) == 0) ? $urandom_range(66, 30)
                                              : $urandom_range(short_cap, 1);
               send_message(len);
            end
         end
         push_drain();
      end
      calm = 1'b0;

      settle();
      repeat (20) @(posedge clock);
      $display("covered %0d requests: %0d messages stored, %0d refused",
               taken_count, stored_msgs, refused_msgs);
      $display("%0d bytes drained over %0d length limits", drained_bytes, csr_writes + 1);
      if (err_count == 0 && due_results.size() == 0) begin
         $display("tb_variable_message_byte_ring_core: PASS");
      end else begin
         $display("tb_variable_message_byte_ring_core: FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_variable_message_byte_ring_core: FAIL");
      $finish;
   end

endmodule
